[hw/rtl/gtur_pkg.sv]
package gtur_pkg;

  // Unit store size in bytes
  localparam int unsigned MAX_UNIT_BYTES = 64 * 1024;

  // Held byte count must reach MAX_UNIT_BYTES itself
  localparam int unsigned HELD_W = $clog2(MAX_UNIT_BYTES + 1);
  // Width of held length plus one packet payload, with room for the carry
  localparam int unsigned SUM_W  = ((HELD_W > 16) ? HELD_W : 16) + 1;
  // Reported lengths and offsets are 17 bits
  localparam int unsigned OUT_W  = 17;

  // Drop size class thresholds
  localparam logic [15:0] CLASS0_MAX = 16'd1;
  localparam logic [15:0] CLASS1_MAX = 16'd5;
  localparam logic [15:0] CLASS2_MAX = 16'd15;

  // Configuration register map
  localparam int unsigned PADDR_W     = 3;
  localparam logic        REG_GAP_LIM = 1'b0;   // register index, paddr[2]
  localparam logic [15:0] GAP_LIM_RST = 16'd2;

  typedef struct packed {
    logic [15:0] packet_seq;
    logic        end_of_unit;
    logic [15:0] payload_bytes;
    logic [15:0] source_id;
  } item_t;

  typedef struct packed {
    logic [15:0]      unit_source;
    logic             unit_done;
    logic [OUT_W-1:0] unit_length;
    logic [15:0]      unit_first_seq;
    logic             unit_dropped;
    logic [1:0]       drop_size_class;
    logic             burst_gap;
    logic [15:0]      skipped_count;
    logic             store_payload;
    logic [OUT_W-1:0] store_offset;
  } result_t;

  // Packet count classification reported on a drop
  function automatic logic [1:0] size_class(input logic [15:0] count);
    logic [1:0] cls;
    if (count <= CLASS0_MAX)      cls = 2'd0;
    else if (count <= CLASS1_MAX) cls = 2'd1;
    else if (count <= CLASS2_MAX) cls = 2'd2;
    else                          cls = 2'd3;
    return cls;
  endfunction

  // Byte count as reported: low 17 bits
  function automatic logic [OUT_W-1:0] to_out(input logic [HELD_W-1:0] v);
    logic [OUT_W+HELD_W-1:0] ext;
    ext = {{OUT_W{1'b0}}, v};
    return ext[OUT_W-1:0];
  endfunction

endpackage

[hw/rtl/gtur_if.sv]
// Packet descriptor channel
interface gtur_pkt_if;
  logic        valid;
  logic        ready;
  logic [15:0] packet_seq;
  logic        end_of_unit;
  logic [15:0] payload_bytes;
  logic [15:0] source_id;

  modport source (output valid, packet_seq, end_of_unit, payload_bytes, source_id,
                  input ready);
  modport sink   (input valid, packet_seq, end_of_unit, payload_bytes, source_id,
                  output ready);
endinterface

// Result channel
interface gtur_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] unit_source;
  logic        unit_done;
  logic [16:0] unit_length;
  logic [15:0] unit_first_seq;
  logic        unit_dropped;
  logic [1:0]  drop_size_class;
  logic        burst_gap;
  logic [15:0] skipped_count;
  logic        store_payload;
  logic [16:0] store_offset;

  modport source (output valid, unit_source, unit_done, unit_length, unit_first_seq,
                  unit_dropped, drop_size_class, burst_gap, skipped_count,
                  store_payload, store_offset,
                  input ready);
  modport sink   (input valid, unit_source, unit_done, unit_length, unit_first_seq,
                  unit_dropped, drop_size_class, burst_gap, skipped_count,
                  store_payload, store_offset,
                  output ready);
endinterface

[hw/rtl/gtur_regs.sv]
module gtur_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gtur_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [15:0]                   gap_limit_o
);

  logic [15:0] gap_limit_q;
  logic        hit;

  // Word index decode; byte lane bits are ignored
  assign hit = (paddr[2] == gtur_pkg::REG_GAP_LIM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_limit_q <= gtur_pkg::GAP_LIM_RST;
    end else if (psel && penable && pwrite && hit) begin
      gap_limit_q <= pwdata[15:0];
    end
  end

  assign prdata      = hit ? {16'd0, gap_limit_q} : 32'd0;
  assign pready      = 1'b1;
  assign gap_limit_o = gap_limit_q;

endmodule

[hw/rtl/gtur_in_stage.sv]
module gtur_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gtur_pkg::item_t     in_item_i,
  output logic                item_valid_o,
  input  logic                item_take_i,
  output gtur_pkg::item_t     item_o
);

  logic            valid_q;
  gtur_pkg::item_t item_q;

  // Register is free when empty or being drained this cycle
  assign in_ready_o = !valid_q || item_take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

[hw/rtl/gtur_core.sv]
module gtur_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [15:0]         gap_limit_i,
  input  logic                item_valid_i,
  output logic                item_take_o,
  input  gtur_pkg::item_t     item_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output gtur_pkg::result_t   res_o
);

  localparam int unsigned HW = gtur_pkg::HELD_W;
  localparam int unsigned SW = gtur_pkg::SUM_W;

  // Unit state
  logic          open_q,  open_d;
  logic [HW-1:0] held_q,  held_d;
  logic [15:0]   start_q, start_d;
  logic [15:0]   next_q,  next_d;
  logic [15:0]   skip_q,  skip_d;

  // Result register
  logic              res_valid_q;
  gtur_pkg::result_t res_q, res_d;

  logic          fire;
  logic [15:0]   gap;
  logic [16:0]   skip_sum;
  logic [SW-1:0] sum;
  logic          fits;

  // Item moves into the result register when that register is free
  assign fire        = item_valid_i && (!res_valid_q || res_ready_i);
  assign item_take_o = fire;

  assign gap      = item_i.packet_seq - next_q;
  assign skip_sum = {1'b0, skip_q} + {1'b0, gap};

  always_comb begin
    open_d  = open_q;
    held_d  = held_q;
    start_d = start_q;
    next_d  = next_q;
    skip_d  = skip_q;
    res_d   = '0;
    sum     = '0;
    fits    = 1'b0;

    // Sequence gap inside an open unit: skip or drop
    if (open_q && (item_i.packet_seq != next_q)) begin
      if (skip_sum <= {1'b0, gap_limit_i}) begin
        skip_d              = skip_sum[15:0];
        res_d.skipped_count = gap;
      end else begin
        res_d.unit_dropped    = 1'b1;
        res_d.drop_size_class = gtur_pkg::size_class(item_i.packet_seq - start_q);
        res_d.burst_gap       = (gap > 16'd1);
        open_d                = 1'b0;
        held_d                = '0;
      end
    end

    if (item_i.end_of_unit) begin
      if (open_d && (held_d != '0)) begin
        // Close open unit, store tail payload if it fits
        sum  = SW'(held_d) + SW'(item_i.payload_bytes);
        fits = (sum <= SW'(gtur_pkg::MAX_UNIT_BYTES));
        res_d.unit_length = gtur_pkg::to_out(held_d);
        if (fits) begin
          res_d.store_payload = 1'b1;
          res_d.store_offset  = gtur_pkg::to_out(held_d);
          res_d.unit_length   = gtur_pkg::to_out(HW'(sum));
        end
        res_d.unit_source    = item_i.source_id;
        res_d.unit_done      = 1'b1;
        res_d.unit_first_seq = start_d;
      end else if (!open_d && (item_i.payload_bytes != 16'd0)) begin
        // Lone end packet forms a unit by itself
        res_d.store_payload  = 1'b1;
        res_d.store_offset   = '0;
        start_d              = item_i.packet_seq;
        next_d               = item_i.packet_seq + 16'd1;
        res_d.unit_source    = item_i.source_id;
        res_d.unit_done      = 1'b1;
        res_d.unit_length    = {1'b0, item_i.payload_bytes};
        res_d.unit_first_seq = item_i.packet_seq;
      end
      open_d = 1'b0;
      held_d = '0;
      skip_d = '0;
    end else begin
      // Middle packet opens a unit if none is open
      if (!open_d) begin
        open_d  = 1'b1;
        held_d  = '0;
        start_d = item_i.packet_seq;
        skip_d  = '0;
      end
      sum  = SW'(held_d) + SW'(item_i.payload_bytes);
      fits = (sum <= SW'(gtur_pkg::MAX_UNIT_BYTES));
      if (fits) begin
        res_d.store_payload = 1'b1;
        res_d.store_offset  = gtur_pkg::to_out(held_d);
        held_d              = HW'(sum);
        next_d              = item_i.packet_seq + 16'd1;
      end else begin
        // Store overflow drops the unit
        res_d.unit_dropped    = 1'b1;
        res_d.drop_size_class = gtur_pkg::size_class(item_i.packet_seq - start_d);
        res_d.burst_gap       = ((item_i.packet_seq - next_d) > 16'd1);
        open_d                = 1'b0;
        held_d                = '0;
      end
    end
  end

  // State and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      held_q      <= '0;
      start_q     <= '0;
      next_q      <= '0;
      skip_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        open_q  <= open_d;
        held_q  <= held_d;
        start_q <= start_d;
        next_q  <= next_d;
        skip_q  <= skip_d;
      end
      if (fire) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[hw/rtl/gap_tolerant_unit_reassembler.sv]
// Gap-tolerant video unit reassembler. Every packet descriptor on pkt_i yields
// exactly one result transaction on res_o, in order. One descriptor is accepted
// per clock cycle when res_o is drained every cycle; a descriptor passes through the
// input register, then the result register, and the unit state is updated as
// each descriptor enters the result register. A stalled res_o holds one result
// and one descriptor, after which pkt_i.ready drops. gap_limit (APB, byte
// address 0, reset 2) may only be written while no transactions are in flight.
module gap_tolerant_unit_reassembler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gtur_pkt_if.sink                      pkt_i,
  gtur_res_if.source                    res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gtur_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic              [15:0] gap_limit;
  gtur_pkg::item_t   in_item;
  gtur_pkg::item_t   item;
  logic              item_valid;
  logic              item_take;
  gtur_pkg::result_t res;

  // Configuration register
  gtur_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .gap_limit_o (gap_limit)
  );

  assign in_item.packet_seq    = pkt_i.packet_seq;
  assign in_item.end_of_unit   = pkt_i.end_of_unit;
  assign in_item.payload_bytes = pkt_i.payload_bytes;
  assign in_item.source_id     = pkt_i.source_id;

  // Input register
  gtur_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (pkt_i.valid),
    .in_ready_o   (pkt_i.ready),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_take_i  (item_take),
    .item_o       (item)
  );

  // Unit state and result register
  gtur_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .gap_limit_i  (gap_limit),
    .item_valid_i (item_valid),
    .item_take_o  (item_take),
    .item_i       (item),
    .res_valid_o  (res_o.valid),
    .res_ready_i  (res_o.ready),
    .res_o        (res)
  );

  assign res_o.unit_source     = res.unit_source;
  assign res_o.unit_done       = res.unit_done;
  assign res_o.unit_length     = res.unit_length;
  assign res_o.unit_first_seq  = res.unit_first_seq;
  assign res_o.unit_dropped    = res.unit_dropped;
  assign res_o.drop_size_class = res.drop_size_class;
  assign res_o.burst_gap       = res.burst_gap;
  assign res_o.skipped_count   = res.skipped_count;
  assign res_o.store_payload   = res.store_payload;
  assign res_o.store_offset    = res.store_offset;

endmodule
